FILE: rtl/core/hltcm_pkg.sv
// Shared types and constants of the hi/lo time coincidence matcher.
// Used by hltcm_regs, hltcm_cmp, hltcm_engine and the top level.
package hltcm_pkg;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [1:0] REQ_CLEAR = 2'd0;
	localparam logic [1:0] REQ_LOAD  = 2'd1;
	localparam logic [1:0] REQ_MATCH = 2'd2;

	localparam logic [1:0] REG_WINDOW = 2'd0;
	localparam logic [1:0] REG_UPPER  = 2'd1;
	localparam logic [1:0] REG_LOWER  = 2'd2;

	localparam logic [15:0]        WINDOW_RST = 16'd8;
	localparam logic signed [20:0] UPPER_RST  = 21'sd1000;
	localparam logic signed [20:0] LOWER_RST  = -21'sd1000;

	typedef struct packed {
		logic [15:0]        window;
		logic signed [20:0] upper;
		logic signed [20:0] lower;
	} cfg_t;

	typedef struct packed {
		logic above;
		logic below;
		logic win;
	} cmp_flags_t;

endpackage

FILE: rtl/core/hltcm_regs.sv
// Configuration registers of the matcher behind an APB-style port.
// Depends on hltcm_pkg for the register map and reset values.
module hltcm_regs import hltcm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic       wr;
	logic [1:0] sel;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign sel    = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.window <= WINDOW_RST;
			cfg.upper  <= UPPER_RST;
			cfg.lower  <= LOWER_RST;
		end else if (wr) begin
			unique case (sel)
				REG_WINDOW: cfg.window <= pwdata[15:0];
				REG_UPPER:  cfg.upper  <= pwdata[20:0];
				REG_LOWER:  cfg.lower  <= pwdata[20:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			REG_WINDOW: prdata = {16'b0, cfg.window};
			REG_UPPER:  prdata = DATA_W'($signed(cfg.upper));
			REG_LOWER:  prdata = DATA_W'($signed(cfg.lower));
			default:    prdata = '0;
		endcase
	end

endmodule

FILE: rtl/core/hltcm_cmp.sv
// Difference stage of the scan pipeline: registers low minus high time and
// classifies it against the scan range and window. Depends on hltcm_pkg.
module hltcm_cmp import hltcm_pkg::*; #(
	parameter int TIME_BITS = 48,
	parameter int IDX_BITS  = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 flush,
	input  logic                 in_valid,
	input  logic [IDX_BITS-1:0]  in_idx,
	input  logic [TIME_BITS-1:0] low,
	input  logic [TIME_BITS-1:0] hi_in,
	output logic                 valid_s2,
	output logic [IDX_BITS-1:0]  idx_s2,
	output logic [TIME_BITS-1:0] hi_s2,
	output cmp_flags_t           flags
);

	localparam int DW = (TIME_BITS + 1 > 22) ? TIME_BITS + 1 : 22;

	logic signed [DW-1:0] diff_s2;
	logic signed [DW-1:0] up_x;
	logic signed [DW-1:0] lo_x;
	logic signed [DW-1:0] win_x;
	logic signed [DW-1:0] neg_win;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= in_valid && !flush;
		end
	end

	always_ff @(posedge clk) begin
		idx_s2  <= in_idx;
		hi_s2   <= hi_in;
		diff_s2 <= DW'(low) - DW'(hi_in);
	end

	assign up_x    = DW'($signed(cfg.upper));
	assign lo_x    = DW'($signed(cfg.lower));
	assign win_x   = DW'($signed({1'b0, cfg.window}));
	assign neg_win = -win_x;

	assign flags.above = diff_s2 > up_x;
	assign flags.below = diff_s2 < lo_x;
	assign flags.win   = (diff_s2 < win_x) && (diff_s2 > neg_win);

endmodule

FILE: rtl/core/hltcm_engine.sv
// Request sequencer with the high time store and the match buffer.
// Depends on hltcm_pkg and hltcm_cmp.
module hltcm_engine import hltcm_pkg::*; #(
	parameter int HIGH_DEPTH  = 256,
	parameter int MAX_MATCHES = 16,
	parameter int TIME_BITS   = 48
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           req_type,
	input  logic [TIME_BITS-1:0] event_time,
	input  logic [1:0]           channel,
	output logic                 hit_strobe,
	output logic [1:0]           hit_channel,
	output logic [TIME_BITS-1:0] low_time,
	output logic [TIME_BITS-1:0] high_time,
	output logic                 high_valid,
	output logic                 last_of_run,
	output logic                 dropped
);

	localparam int IDXW = $clog2(HIGH_DEPTH);
	localparam int CW   = $clog2(HIGH_DEPTH + 1);
	localparam int MW   = (MAX_MATCHES > 1) ? $clog2(MAX_MATCHES) : 1;
	localparam int NW   = $clog2(MAX_MATCHES + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EMIT} state_t;

	state_t               state_q;
	logic [CW-1:0]        count_q;
	logic [IDXW-1:0]      start_q;
	logic                 sovf_q;
	logic [CW-1:0]        issue_q;
	logic                 v_s1;
	logic [IDXW-1:0]      idx_s1;
	logic [TIME_BITS-1:0] rd_s1;
	logic [NW-1:0]        nmatch_q;
	logic                 ovf_q;
	logic [NW-1:0]        e_q;
	logic [1:0]           ch_q;
	logic [TIME_BITS-1:0] t_q;
	logic [TIME_BITS-1:0] brd_q;

	logic [TIME_BITS-1:0] store [HIGH_DEPTH];
	logic [TIME_BITS-1:0] mbuf  [MAX_MATCHES];

	logic                 v_s2;
	logic [IDXW-1:0]      idx_s2;
	logic [TIME_BITS-1:0] hi_s2;
	cmp_flags_t           fl;

	logic acc, can_issue, skip, stop, take, drained, scan_end, issue;
	logic st_we, buf_we, emit, lowonly, emit_last;

	assign acc       = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign can_issue = issue_q < count_q;
	assign skip      = v_s2 && fl.above;
	assign stop      = v_s2 && !fl.above && fl.below;
	assign take      = v_s2 && !fl.above && !fl.below && fl.win;
	assign drained   = !can_issue && !v_s1 && !v_s2;
	assign scan_end  = (state_q == ST_SCAN) && (stop || drained);
	assign issue     = (state_q == ST_SCAN) && can_issue && !stop;
	assign st_we     = acc && (req_type == REQ_LOAD) && (count_q < CW'(HIGH_DEPTH));
	assign buf_we    = (state_q == ST_SCAN) && take && (nmatch_q < NW'(MAX_MATCHES));
	assign emit      = (state_q == ST_EMIT);
	assign lowonly   = scan_end && (nmatch_q == '0);
	assign emit_last = (e_q + NW'(1)) == nmatch_q;

	hltcm_cmp #(
		.TIME_BITS(TIME_BITS),
		.IDX_BITS (IDXW)
	) u_cmp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.flush   (stop),
		.in_valid(v_s1),
		.in_idx  (idx_s1),
		.low     (t_q),
		.hi_in   (rd_s1),
		.valid_s2(v_s2),
		.idx_s2  (idx_s2),
		.hi_s2   (hi_s2),
		.flags   (fl)
	);

	always_ff @(posedge clk) begin
		if (st_we) begin
			store[count_q[IDXW-1:0]] <= event_time;
		end
		if (issue) begin
			rd_s1 <= store[issue_q[IDXW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (buf_we) begin
			mbuf[nmatch_q[MW-1:0]] <= hi_s2;
		end
		if (emit) begin
			brd_q <= mbuf[e_q[MW-1:0]];
		end else if (lowonly) begin
			brd_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && (req_type == REQ_MATCH)) begin
			t_q  <= event_time;
			ch_q <= channel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			start_q     <= '0;
			sovf_q      <= 1'b0;
			issue_q     <= '0;
			v_s1        <= 1'b0;
			idx_s1      <= '0;
			nmatch_q    <= '0;
			ovf_q       <= 1'b0;
			e_q         <= '0;
			hit_strobe  <= 1'b0;
			high_valid  <= 1'b0;
			last_of_run <= 1'b0;
			dropped     <= 1'b0;
		end else begin
			v_s1       <= issue;
			unique case (state_q)
				ST_IDLE: begin
					hit_strobe <= 1'b0;
					if (acc) begin
						unique case (req_type)
							REQ_CLEAR: begin
								count_q <= '0;
								start_q <= '0;
								sovf_q  <= 1'b0;
							end
							REQ_LOAD: begin
								if (st_we) begin
									count_q <= count_q + CW'(1);
								end else begin
									sovf_q <= 1'b1;
								end
							end
							REQ_MATCH: begin
								issue_q  <= CW'(start_q);
								nmatch_q <= '0;
								ovf_q    <= 1'b0;
								state_q  <= ST_SCAN;
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					hit_strobe <= lowonly;
					if (issue) begin
						idx_s1  <= issue_q[IDXW-1:0];
						issue_q <= issue_q + CW'(1);
					end
					if (skip) begin
						start_q <= idx_s2;
					end
					if (take) begin
						if (buf_we) begin
							nmatch_q <= nmatch_q + NW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
					if (scan_end) begin
						if (lowonly) begin
							high_valid  <= 1'b0;
							last_of_run <= 1'b1;
							dropped     <= sovf_q;
							state_q     <= ST_IDLE;
						end else begin
							e_q     <= '0;
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					hit_strobe  <= 1'b1;
					high_valid  <= 1'b1;
					last_of_run <= emit_last;
					dropped     <= ovf_q || sovf_q;
					e_q         <= e_q + NW'(1);
					if (emit_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					hit_strobe <= 1'b0;
					state_q    <= ST_IDLE;
				end
			endcase
		end
	end

	assign hit_channel = ch_q;
	assign low_time    = t_q;
	assign high_time   = brd_q;

endmodule

FILE: rtl/core/hi_lo_time_coincidence_matcher.sv
// Top level of the hi/lo time coincidence matcher.
// Depends on hltcm_pkg, hltcm_regs and hltcm_engine.
//
// Usage:
// - Requests: start with req_type, event_time and channel; a transfer
//   happens at a clock edge with start high and busy low.
// - Clear and load requests complete without raising busy and give no hit.
// - A match request scans the high time store from the start pointer, one
//   store read per cycle through a read/subtract/compare pipeline, then
//   plays out its hits from the match buffer, one per cycle. busy stays
//   high through the scan, which ends early when a high time past the range
//   is read, and through the playout of the hits; the last hit strobes in
//   the first idle cycle.
// - Hits: hit_strobe marks each hit for exactly one cycle; the receiver
//   cannot stall, so every hit must be taken when strobed.
// - Configuration: APB port, registers at byte addresses 0, 4 and 8; write
//   only while busy is low and no hit is pending. pready is always high.
// - Reset: arst_n clears the store count, start pointer, overflow flag and
//   registers to their defaults; store contents are undefined until loaded.
module hi_lo_time_coincidence_matcher import hltcm_pkg::*; #(
	parameter int HIGH_DEPTH  = 256,
	parameter int MAX_MATCHES = 16,
	parameter int TIME_BITS   = 48
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_W-1:0]    paddr,
	input  logic [DATA_W-1:0]    pwdata,
	output logic [DATA_W-1:0]    prdata,
	output logic                 pready,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           req_type,
	input  logic [TIME_BITS-1:0] event_time,
	input  logic [1:0]           channel,
	output logic                 hit_strobe,
	output logic [1:0]           hit_channel,
	output logic [TIME_BITS-1:0] low_time,
	output logic [TIME_BITS-1:0] high_time,
	output logic                 high_valid,
	output logic                 last_of_run,
	output logic                 dropped
);

	cfg_t cfg;

	hltcm_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	hltcm_engine #(
		.HIGH_DEPTH (HIGH_DEPTH),
		.MAX_MATCHES(MAX_MATCHES),
		.TIME_BITS  (TIME_BITS)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.event_time (event_time),
		.channel    (channel),
		.hit_strobe (hit_strobe),
		.hit_channel(hit_channel),
		.low_time   (low_time),
		.high_time  (high_time),
		.high_valid (high_valid),
		.last_of_run(last_of_run),
		.dropped    (dropped)
	);

endmodule

FILE: tb/sv/testbench.sv
// Testbench for hi_lo_time_coincidence_matcher: directed table, then random events per setting.
// Own predictor of the store and scan; every hit is checked against it in order of arrival.
// Depends on hltcm_pkg and the matcher RTL.
`timescale 1ns / 1ps

module testbench;
	import hltcm_pkg::*;

	localparam int HIGH_DEPTH  = 256;
	localparam int MAX_MATCHES = 16;
	localparam int TIME_W      = 48;

	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]        chan;
		logic [TIME_W-1:0] lo;
		logic [TIME_W-1:0] hi;
		logic              matched;
		logic              last_hit;
		logic              dropped_flag;
	} hit_t;

	typedef struct packed {
		logic [1:0]        rq;
		logic [TIME_W-1:0] t;
		logic [1:0]        ch;
		logic              typed;
		hit_t              want;
	} row_t;

	localparam hit_t NONE = '0;

	row_t directed_rows [21] = '{
		'{REQ_MATCH,  48'd0,               2'd1, 1'b1, '{2'd1, 48'd0, 48'd0, 1'b0, 1'b1, 1'b0}},
		'{REQ_CLEAR,  48'd0,               2'd1, 1'b0, NONE},
		'{REQ_LOAD,   48'd100,             2'd1, 1'b0, NONE},
		'{REQ_LOAD,   48'd105,             2'd2, 1'b0, NONE},
		'{REQ_LOAD,   48'd2000,            2'd1, 1'b0, NONE},
		'{REQ_MATCH,  48'd103,             2'd2, 1'b0, NONE},
		'{REQ_MATCH,  48'd1500,            2'd1, 1'b0, NONE},
		'{REQ_MATCH,  48'd2007,            2'd3, 1'b0, NONE},
		'{REQ_MATCH,  48'd2008,            2'd0, 1'b0, NONE},
		'{REQ_UNUSED, 48'd12345,           2'd2, 1'b0, NONE},
		'{REQ_MATCH,  48'd2001,            2'd1, 1'b0, NONE},
		'{REQ_CLEAR,  48'hFFFF_FFFF_FFFF,  2'd3, 1'b0, NONE},
		'{REQ_LOAD,   48'hFFFF_FFFF_FFFF,  2'd2, 1'b0, NONE},
		'{REQ_LOAD,   48'd0,               2'd1, 1'b0, NONE},
		'{REQ_MATCH,  48'hFFFF_FFFF_FFFF,  2'd2, 1'b0, NONE},
		'{REQ_MATCH,  48'd0,               2'd1, 1'b0, NONE},
		'{REQ_MATCH,  48'hAAAA_AAAA_AAAA,  2'd2, 1'b0, NONE},
		'{REQ_MATCH,  48'h5555_5555_5555,  2'd1, 1'b0, NONE},
		'{REQ_CLEAR,  48'd0,               2'd2, 1'b0, NONE},
		'{REQ_UNUSED, 48'hFFFF_FFFF_FFFF,  2'd3, 1'b0, NONE},
		'{REQ_MATCH,  48'd7,               2'd1, 1'b1, '{2'd1, 48'd7, 48'd0, 1'b0, 1'b1, 1'b0}}
	};

	logic              clk;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              start = 1'b0;
	logic              busy;
	logic [1:0]        req_type = '0;
	logic [TIME_W-1:0] event_time = '0;
	logic [1:0]        channel = '0;
	logic              hit_strobe;
	logic [1:0]        hit_channel;
	logic [TIME_W-1:0] low_time;
	logic [TIME_W-1:0] high_time;
	logic              high_valid;
	logic              last_of_run;
	logic              dropped;

	logic [TIME_W-1:0] high_store [HIGH_DEPTH];
	int                high_count = 0;
	int                scan_start = 0;
	bit                store_full_seen = 1'b0;
	int                cfg_window = WINDOW_RST;
	int                cfg_upper = UPPER_RST;
	int                cfg_lower = LOWER_RST;

	hit_t pending_hits [$];
	int   mismatches = 0;
	int   requests = 0;
	int   hits_checked = 0;
	int   dropped_hits = 0;
	int   settings_used = 0;
	int   idle_pct = 0;

	hi_lo_time_coincidence_matcher #(
		.HIGH_DEPTH (HIGH_DEPTH),
		.MAX_MATCHES(MAX_MATCHES),
		.TIME_BITS  (TIME_W)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.event_time (event_time),
		.channel    (channel),
		.hit_strobe (hit_strobe),
		.hit_channel(hit_channel),
		.low_time   (low_time),
		.high_time  (high_time),
		.high_valid (high_valid),
		.last_of_run(last_of_run),
		.dropped    (dropped)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("simulation failed");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 40) begin
			$display("%0t mismatch: %s", $time, msg);
		end
	endtask

	function automatic void predict_hits(input logic [1:0] rq, input logic [TIME_W-1:0] t,
			input logic [1:0] ch, output hit_t out_hits [$]);
		logic [TIME_W-1:0] matched_times [$];
		bit                excess;
		longint            diff;
		longint            mag;
		int                i;
		hit_t              h;
		out_hits.delete();
		excess = 1'b0;
		case (rq)
			REQ_CLEAR: begin
				high_count = 0;
				scan_start = 0;
				store_full_seen = 1'b0;
			end
			REQ_LOAD: begin
				if (high_count < HIGH_DEPTH) begin
					high_store[high_count] = t;
					high_count++;
				end else begin
					store_full_seen = 1'b1;
				end
			end
			REQ_MATCH: begin
				for (i = scan_start; i < high_count; i++) begin
					diff = longint'({16'd0, t}) - longint'({16'd0, high_store[i]});
					if (diff > cfg_upper) begin
						scan_start = i;
						continue;
					end
					if (diff < cfg_lower) break;
					mag = (diff < 0) ? -diff : diff;
					if (mag < cfg_window) begin
						if (matched_times.size() < MAX_MATCHES)
							matched_times.insert(matched_times.size(), high_store[i]);
						else excess = 1'b1;
					end
				end
				if (matched_times.size() == 0) begin
					h = '{ch, t, '0, 1'b0, 1'b1, store_full_seen};
					out_hits.insert(out_hits.size(), h);
				end else begin
					foreach (matched_times[n]) begin
						h = '{ch, t, matched_times[n], 1'b1, n == matched_times.size() - 1,
							excess | store_full_seen};
						out_hits.insert(out_hits.size(), h);
					end
				end
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk) begin : hit_monitor
		hit_t seen;
		hit_t want;
		if (arst_n && hit_strobe) begin
			seen = '{hit_channel, low_time, high_time, high_valid, last_of_run, dropped};
			hits_checked++;
			if (dropped) dropped_hits++;
			if (pending_hits.size() == 0) begin
				report_mismatch($sformatf("unexpected hit ch %0d low %h high %h",
					hit_channel, low_time, high_time));
			end else begin
				want = pending_hits.pop_front();
				if (seen !== want) begin
					report_mismatch($sformatf(
						"got ch %0d lo %h hi %h v%b l%b d%b, want ch %0d lo %h hi %h v%b l%b d%b",
						seen.chan, seen.lo, seen.hi, seen.matched, seen.last_hit,
						seen.dropped_flag, want.chan, want.lo, want.hi, want.matched,
						want.last_hit, want.dropped_flag));
				end
			end
		end
	end

	function automatic logic [TIME_W-1:0] rand_time();
		return {16'($urandom), $urandom};
	endfunction

	function automatic logic [1:0] pick_channel();
		if ($urandom_range(0, 9) == 0) return 2'($urandom_range(0, 3));
		return 2'($urandom_range(1, 2));
	endfunction

	task automatic send_request(input logic [1:0] rq, input logic [TIME_W-1:0] t,
			input logic [1:0] ch, input logic typed, input hit_t typed_hit);
		hit_t produced [$];
		if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		start <= 1'b1;
		req_type <= rq;
		event_time <= t;
		channel <= ch;
		do @(posedge clk); while (busy);
		predict_hits(rq, t, ch, produced);
		if (typed) begin
			produced.delete();
			produced.insert(0, typed_hit);
		end
		foreach (produced[k]) pending_hits.insert(pending_hits.size(), produced[k]);
		if (rq != REQ_UNUSED) requests++;
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending_hits.size() != 0 || busy);
		repeat (8) @(posedge clk);
	endtask

	// write then read back; psel stays high between registers
	task automatic program_reg(input logic [1:0] idx, input logic [31:0] val,
			input logic [31:0] mask);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if ((prdata & mask) !== (val & mask)) begin
			report_mismatch($sformatf("register %0d reads %h, wrote %h", idx, prdata, val));
		end
	endtask

	task automatic apply_settings(input int win, input int up, input int lo);
		program_reg(REG_WINDOW, 32'(win), 32'h0000_FFFF);
		program_reg(REG_UPPER, 32'(up), 32'h001F_FFFF);
		program_reg(REG_LOWER, 32'(lo), 32'h001F_FFFF);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		cfg_window = win;
		cfg_upper = up;
		cfg_lower = lo;
		settings_used++;
	endtask

	task automatic run_events(input int target, input bit with_fill);
		logic [TIME_W-1:0] base;
		logic [TIME_W-1:0] ht;
		logic [TIME_W-1:0] lt;
		int                nh;
		int                gmax;
		bit                fill_pending;
		fill_pending = with_fill;
		while (requests < target) begin
			if ($urandom_range(0, 99) < 12) begin
				send_request(2'($urandom_range(0, 3)), rand_time(), pick_channel(), 1'b0, NONE);
			end else begin
				case ($urandom_range(0, 2))
					0: gmax = 1;
					1: gmax = 12;
					default: gmax = 400;
				endcase
				nh = $urandom_range(0, 20);
				if (fill_pending) begin
					nh = HIGH_DEPTH + $urandom_range(1, 4);
					gmax = 1;
				end
				fill_pending = 1'b0;
				case ($urandom_range(0, 9))
					0: base = '0;
					1: base = 48'hFFFF_FFFF_0000 + $urandom_range(0, 1000);
					default: base = rand_time() >> 1;
				endcase
				send_request(REQ_CLEAR, rand_time(), pick_channel(), 1'b0, NONE);
				ht = base;
				repeat (nh) begin
					ht += $urandom_range(0, gmax);
					send_request(REQ_LOAD, ht, pick_channel(), 1'b0, NONE);
				end
				lt = (base >= 2 * gmax) ? base - $urandom_range(0, 2 * gmax) : base;
				repeat ($urandom_range(1, 10)) begin
					lt += $urandom_range(0, 2 * gmax);
					send_request(REQ_MATCH, lt, pick_channel(), 1'b0, NONE);
				end
				// broken sequence: late load, then one more seed
				if ($urandom_range(0, 9) == 0) begin
					send_request(REQ_LOAD, ht - $urandom_range(0, 50), pick_channel(), 1'b0, NONE);
					send_request(REQ_MATCH, lt + $urandom_range(0, 50), pick_channel(), 1'b0, NONE);
				end
			end
		end
	endtask

	initial begin : stimulus
		int win_set [6];
		int up_set [6];
		int lo_set [6];
		int idle_set [6];
		win_set = '{65535, 0, WINDOW_RST, 0, 0, 0};
		up_set = '{1048575, -1048576, UPPER_RST, 0, 0, 0};
		lo_set = '{-1048576, 1048575, LOWER_RST, 0, 0, 0};
		idle_set = '{25, 25, 20, 0, 30, 0};
		for (int p = 3; p < 6; p++) begin
			win_set[p] = $urandom_range(0, 400);
			up_set[p] = int'($urandom_range(0, 3000)) - 500;
			lo_set[p] = 500 - int'($urandom_range(0, 3000));
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		idle_pct = 20;
		foreach (directed_rows[r]) begin
			send_request(directed_rows[r].rq, directed_rows[r].t, directed_rows[r].ch,
				directed_rows[r].typed, directed_rows[r].want);
		end

		for (int p = 0; p < 6; p++) begin
			drain();
			apply_settings(win_set[p], up_set[p], lo_set[p]);
			idle_pct = idle_set[p];
			run_events(requests + 10, p == 2);
		end

		drain();
		repeat (64) @(posedge clk);
		$display("%0d requests over %0d register settings; %0d hits checked, %0d flagged dropped",
			requests, settings_used, hits_checked, dropped_hits);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
